/* sv/jan_pkg.sv */
`timescale 1ns / 1ps
// Shared constants for the joystick axis auto-range normalizer.
// No dependencies.
package jan_pkg;

  localparam int SAMPLE_BITS = 10;
  localparam int FRAC_BITS   = 15;

  localparam logic OP_NORMALIZE = 1'b0;
  localparam logic OP_CALIBRATE = 1'b1;

endpackage

/* sv/joystick_axis_autorange_normalizer_top.sv */
`timescale 1ns / 1ps
// Two-axis joystick normalizer with auto-ranging extremes and serial divider.
// Depends on jan_pkg.
//
// Each request carries raw X and Y samples and an opcode. A normalize request
// widens each axis's tracked minimum/maximum to include its sample and maps
// the sample to signed fixed point with FRAC_BITS fraction bits, rounded to
// nearest and saturated at +/-(2^FRAC_BITS-1). A calibrate request stores the
// samples as new centres and returns zeros. A normalize request runs, per axis,
// through a setup state, the divider steps and a rounding state, and then
// loads the output. Both axes share one restoring divider that produces one
// quotient bit per cycle. A zero-span axis skips the divider, and a calibrate
// request goes from acceptance straight to loading the output. The input is
// ready again from the cycle in which the loaded result is first presented,
// so a new request is not taken before the last one's result is loaded. The
// input is not ready while a request is in work; the next request may be
// taken while the result waits, and its own result is held back until the
// waiting one has been taken.
module joystick_axis_autorange_normalizer_top #(
  parameter int SAMPLE_BITS = jan_pkg::SAMPLE_BITS,
  parameter int FRAC_BITS   = jan_pkg::FRAC_BITS,
  localparam int InW  = ((2 * SAMPLE_BITS + 7) / 8) * 8,
  localparam int OutW = ((2 * (FRAC_BITS + 1) + 7) / 8) * 8
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            s_axis_tvalid,
  output logic            s_axis_tready,
  input  logic [InW-1:0]  s_axis_tdata,   // raw_x, raw_y, zero pad
  input  logic            s_axis_tuser,   // opcode
  output logic            m_axis_tvalid,
  input  logic            m_axis_tready,
  output logic [OutW-1:0] m_axis_tdata    // norm_x, norm_y, zero pad
);

  localparam int S    = SAMPLE_BITS;
  localparam int F    = FRAC_BITS;
  localparam int NumW = S + F + 1;
  localparam int CntW = $clog2(F + 1);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_PREP = 3'd1;
  localparam logic [2:0] ST_DIV  = 3'd2;
  localparam logic [2:0] ST_POST = 3'd3;
  localparam logic [2:0] ST_DONE = 3'd4;

  logic [2:0]      state_q, state_d;
  logic            op_q;
  logic [S-1:0]    samp_q [2];
  logic [S-1:0]    ctr_q  [2];
  logic [S-1:0]    lo_q   [2];
  logic [S-1:0]    hi_q   [2];
  logic            axis_q;
  logic            neg_q;
  logic            zero_q;
  logic [S-1:0]    span_q;
  logic [S:0]      rem_q;
  logic [F:0]      quot_q;
  logic [CntW-1:0] cnt_q;
  logic [F:0]      res_q [2];
  logic            out_vld_q;
  logic [OutW-1:0] out_data_q;

  // per-axis preparation
  logic [S-1:0]    smp, lo_new, hi_new, ctr, delta, span;
  logic            below;
  logic [NumW-1:0] num;

  always_comb begin
    smp    = samp_q[axis_q];
    ctr    = ctr_q[axis_q];
    hi_new = (smp > hi_q[axis_q]) ? smp : hi_q[axis_q];
    lo_new = (smp < lo_q[axis_q]) ? smp : lo_q[axis_q];
    below  = smp < ctr;
    delta  = below ? (ctr - smp) : (smp - ctr);
    span   = below ? (ctr - lo_new) : (hi_new - ctr);
    num    = {1'b0, delta, {F{1'b0}}} + NumW'(span >> 1);
  end

  // shared divider step
  logic [S:0] trial;
  logic       ge;

  always_comb begin
    trial = {rem_q[S-1:0], quot_q[F]};
    ge    = trial >= {1'b0, span_q};
  end

  // saturation and sign
  logic [F-1:0] mag;
  logic [F:0]   res_val;

  always_comb begin
    if (zero_q) begin
      mag = '0;
    end else if (quot_q[F]) begin
      mag = '1;
    end else begin
      mag = quot_q[F-1:0];
    end
    res_val = neg_q ? (~{1'b0, mag} + 1'b1) : {1'b0, mag};
  end

  logic out_free;
  assign out_free = !out_vld_q || m_axis_tready;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (s_axis_tvalid) begin
          state_d = (s_axis_tuser == jan_pkg::OP_CALIBRATE) ? ST_DONE : ST_PREP;
        end
      end
      ST_PREP: begin
        state_d = (span == '0) ? ST_POST : ST_DIV;
      end
      ST_DIV: begin
        if (cnt_q == CntW'(F)) begin
          state_d = ST_POST;
        end
      end
      ST_POST: begin
        state_d = axis_q ? ST_DONE : ST_PREP;
      end
      ST_DONE: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      out_vld_q <= 1'b0;
      axis_q    <= 1'b0;
      cnt_q     <= '0;
      for (int i = 0; i < 2; i++) begin
        ctr_q[i] <= {1'b1, {(S-1){1'b0}}};
        lo_q[i]  <= '1;
        hi_q[i]  <= '0;
      end
    end else begin
      state_q <= state_d;
      if (state_q == ST_DONE && out_free) begin
        out_vld_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_vld_q <= 1'b0;
      end
      unique case (state_q)
        ST_IDLE: begin
          axis_q <= 1'b0;
        end
        ST_PREP: begin
          hi_q[axis_q] <= hi_new;
          lo_q[axis_q] <= lo_new;
          cnt_q        <= '0;
        end
        ST_DIV: begin
          cnt_q <= cnt_q + 1'b1;
        end
        ST_POST: begin
          axis_q <= 1'b1;
        end
        ST_DONE: begin
          if (out_free && op_q == jan_pkg::OP_CALIBRATE) begin
            ctr_q[0] <= samp_q[0];
            ctr_q[1] <= samp_q[1];
          end
        end
        default: ;
      endcase
    end
  end

  // payload, no reset
  always_ff @(posedge clk_i) begin
    if (state_q == ST_IDLE && s_axis_tvalid) begin
      op_q      <= s_axis_tuser;
      samp_q[0] <= s_axis_tdata[S-1:0];
      samp_q[1] <= s_axis_tdata[2*S-1:S];
    end
    unique case (state_q)
      ST_PREP: begin
        neg_q  <= below;
        zero_q <= span == '0;
        span_q <= span;
        rem_q  <= {1'b0, num[NumW-1:F+1]};
        quot_q <= num[F:0];
      end
      ST_DIV: begin
        rem_q  <= ge ? (trial - {1'b0, span_q}) : trial;
        quot_q <= {quot_q[F-1:0], ge};
      end
      ST_POST: begin
        res_q[axis_q] <= res_val;
      end
      ST_DONE: begin
        if (out_free) begin
          out_data_q <= (op_q == jan_pkg::OP_CALIBRATE) ? '0
                                                        : OutW'({res_q[1], res_q[0]});
        end
      end
      default: ;
    endcase
  end

  assign s_axis_tready = state_q == ST_IDLE;
  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = out_data_q;

  a_busy_not_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q != ST_IDLE |-> !s_axis_tready)
    else $error("input ready while busy");

  a_rem_below_span: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_DIV |-> rem_q < {1'b0, span_q})
    else $error("divider remainder out of range");

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_DIV |-> cnt_q <= CntW'(F))
    else $error("divider count overrun");

  a_cal_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $past(state_q) == ST_DONE && $past(out_free)
      && $past(op_q) == jan_pkg::OP_CALIBRATE |-> m_axis_tdata == '0)
    else $error("calibrate result not zero");

  a_done_delivers: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_DONE && out_free |=> m_axis_tvalid && state_q == ST_IDLE)
    else $error("result not presented");

endmodule
